// File: sv/hpi_pkg.sv
// ----------------------------------------------------------------------------
// Hilbert point-to-index package
// Shared widths, register indexes, defaults and the configuration struct.
// ----------------------------------------------------------------------------
package hpi_pkg;

  localparam int HPI_COORD_W    = 15;
  localparam int HPI_NUM_COORDS = 4;
  localparam int HPI_INDEX_W    = 60;
  localparam int HPI_CFG_W      = 4;
  localparam int HPI_CFG_IDX_W  = 1;

  localparam int HPI_MAX_DIMS  = 4;
  localparam int HPI_MAX_ORDER = 15;

  localparam logic [HPI_CFG_IDX_W-1:0] CFG_ORDER_BITS  = 1'b0;
  localparam logic [HPI_CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 1'b1;

  localparam logic [3:0] ORDER_RESET = 4'd15;
  localparam logic [2:0] DIMS_RESET  = 3'd2;

  // Effective (clamped) curve order and dimension count.
  typedef struct packed {
    logic [3:0] order;
    logic [2:0] dims;
  } hpi_cfg_t;

endpackage

// File: sv/hpi_if.sv
// ----------------------------------------------------------------------------
// Hilbert point-to-index channels
// Valid/ready channels for input points and output curve positions.
// ----------------------------------------------------------------------------
interface hpi_point_if;
  logic                           valid;
  logic                           ready;
  logic [hpi_pkg::HPI_COORD_W-1:0] coord_0;
  logic [hpi_pkg::HPI_COORD_W-1:0] coord_1;
  logic [hpi_pkg::HPI_COORD_W-1:0] coord_2;
  logic [hpi_pkg::HPI_COORD_W-1:0] coord_3;

  modport source (output valid, coord_0, coord_1, coord_2, coord_3, input ready);
  modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

interface hpi_index_if;
  logic                           valid;
  logic                           ready;
  logic [hpi_pkg::HPI_INDEX_W-1:0] hilbert_index;

  modport source (output valid, hilbert_index, input ready);
  modport sink   (input valid, hilbert_index, output ready);
endinterface

// File: sv/hpi_undo_stage.sv
// ----------------------------------------------------------------------------
// Hilbert undo stage
// One bit level of the inverse-undo pass, registered, with valid/ready.
// ----------------------------------------------------------------------------
module hpi_undo_stage #(
  parameter int MAX_DIMS  = hpi_pkg::HPI_MAX_DIMS,
  parameter int MAX_ORDER = hpi_pkg::HPI_MAX_ORDER,
  parameter int LEVEL     = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hpi_pkg::hpi_cfg_t                   cfg,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [MAX_DIMS-1:0][MAX_ORDER-1:0]  data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [MAX_DIMS-1:0][MAX_ORDER-1:0]  data_o
);

  localparam logic [MAX_ORDER-1:0] LOW_MASK = MAX_ORDER'((1 << LEVEL) - 1);

  logic                               valid_r;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] data_r;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] data_nxt;
  logic [MAX_ORDER-1:0]               swap;

  always_comb begin
    data_nxt = data_i;
    swap     = '0;
    if (LEVEL < int'(cfg.order)) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (i < int'(cfg.dims)) begin
          if (data_nxt[i][LEVEL]) begin
            data_nxt[0] = data_nxt[0] ^ LOW_MASK;
          end else begin
            swap        = (data_nxt[0] ^ data_nxt[i]) & LOW_MASK;
            data_nxt[0] = data_nxt[0] ^ swap;
            data_nxt[i] = data_nxt[i] ^ swap;
          end
        end
      end
    end
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/hpi_gray_stage.sv
// ----------------------------------------------------------------------------
// Hilbert Gray stage
// Gray encode across the coordinates and the closing correction mask.
// ----------------------------------------------------------------------------
module hpi_gray_stage #(
  parameter int MAX_DIMS  = hpi_pkg::HPI_MAX_DIMS,
  parameter int MAX_ORDER = hpi_pkg::HPI_MAX_ORDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hpi_pkg::hpi_cfg_t                   cfg,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [MAX_DIMS-1:0][MAX_ORDER-1:0]  data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [MAX_DIMS-1:0][MAX_ORDER-1:0]  data_o
);

  logic                               valid_r;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] data_r;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] gray;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] data_nxt;
  logic [MAX_ORDER-1:0]               last;
  logic [MAX_ORDER-1:0]               corr;

  always_comb begin
    gray = data_i;
    for (int i = 1; i < MAX_DIMS; i++) begin
      if (i < int'(cfg.dims)) begin
        gray[i] = gray[i] ^ gray[i-1];
      end
    end

    last = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i + 1 == int'(cfg.dims)) begin
        last = gray[i];
      end
    end

    // Each correction bit is the parity of the last coordinate above it.
    corr = '0;
    for (int j = 0; j < MAX_ORDER - 1; j++) begin
      corr[j] = ^(last & ~MAX_ORDER'((2 << j) - 1));
    end

    data_nxt = gray;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i < int'(cfg.dims)) begin
        data_nxt[i] = gray[i] ^ corr;
      end
    end
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/hpi_pack_stage.sv
// ----------------------------------------------------------------------------
// Hilbert pack stage
// Interleaves the transposed bits MSB-first into the index; output register.
// ----------------------------------------------------------------------------
module hpi_pack_stage #(
  parameter int MAX_DIMS  = hpi_pkg::HPI_MAX_DIMS,
  parameter int MAX_ORDER = hpi_pkg::HPI_MAX_ORDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hpi_pkg::hpi_cfg_t                   cfg,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [MAX_DIMS-1:0][MAX_ORDER-1:0]  data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [MAX_DIMS*MAX_ORDER-1:0]       index_o
);

  localparam int IDX_W = MAX_DIMS * MAX_ORDER;

  logic                          valid_r;
  logic [IDX_W-1:0]              index_r;
  logic [IDX_W-1:0]              index_nxt;
  logic [MAX_DIMS-1:0][IDX_W-1:0] cand;

  // Bits above the curve order are zero, so only the dimension count
  // changes the bit placement; one fixed wiring per count.
  always_comb begin
    cand = '0;
    for (int nv = 1; nv <= MAX_DIMS; nv++) begin
      for (int lvl = 0; lvl < MAX_ORDER; lvl++) begin
        for (int i = 0; i < nv; i++) begin
          cand[nv-1][lvl*nv + nv - 1 - i] = data_i[i][lvl];
        end
      end
    end
    index_nxt = '0;
    for (int nv = 1; nv <= MAX_DIMS; nv++) begin
      if (int'(cfg.dims) == nv) begin
        index_nxt = cand[nv-1];
      end
    end
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign index_o = index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      index_r <= index_nxt;
    end
  end

endmodule

// File: sv/hilbert_point_to_index.sv
// ----------------------------------------------------------------------------
// Hilbert point-to-index converter
// Maps a point of up to four coordinates to its position on a Hilbert curve.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle, unless the input is held off,
// and returns its Hilbert index through a chain of registered stages: one
// pipeline stage per bit level of the undo pass, one for the Gray encode and
// correction, and one output register for the bit interleave. Every stage
// can hold a beat while the output is stalled, and bubbles close up, so the
// input is only held off when all stages are full and the output is not
// taken. Configuration is read directly by every stage and must only be
// written while the pipeline is empty.
module hilbert_point_to_index #(
  parameter int MAX_DIMS  = hpi_pkg::HPI_MAX_DIMS,
  parameter int MAX_ORDER = hpi_pkg::HPI_MAX_ORDER
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hpi_point_if.sink                          in_point,
  hpi_index_if.source                        out_index,
  input  logic                               cfg_we,
  input  logic [hpi_pkg::HPI_CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpi_pkg::HPI_CFG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = MAX_DIMS * MAX_ORDER;

  logic [3:0]        order_r;
  logic [2:0]        dims_r;
  hpi_pkg::hpi_cfg_t cfg;

  logic [hpi_pkg::HPI_NUM_COORDS-1:0][hpi_pkg::HPI_COORD_W-1:0] coords;
  logic [MAX_ORDER-1:0]                                         cmask;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0]                           point_in;

  logic [MAX_ORDER-1:0]               stg_valid;
  logic [MAX_ORDER-1:0]               stg_ready;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] stg_data [MAX_ORDER];

  logic                               gray_valid;
  logic                               gray_ready;
  logic [MAX_DIMS-1:0][MAX_ORDER-1:0] gray_data;
  logic                               pack_ready;
  logic [IDX_W-1:0]                   index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hpi_pkg::ORDER_RESET;
      dims_r  <= hpi_pkg::DIMS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpi_pkg::CFG_ORDER_BITS:  order_r <= cfg_wdata[3:0];
        hpi_pkg::CFG_DIMS_IN_USE: dims_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.order = order_r;
    if (order_r == 4'd0) begin
      cfg.order = 4'd1;
    end else if (int'(order_r) > MAX_ORDER) begin
      cfg.order = 4'(MAX_ORDER);
    end
    cfg.dims = dims_r;
    if (dims_r == 3'd0) begin
      cfg.dims = 3'd1;
    end else if (int'(dims_r) > MAX_DIMS) begin
      cfg.dims = 3'(MAX_DIMS);
    end
  end

  assign coords = {in_point.coord_3, in_point.coord_2, in_point.coord_1, in_point.coord_0};

  always_comb begin
    for (int j = 0; j < MAX_ORDER; j++) begin
      cmask[j] = (j < int'(cfg.order));
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      point_in[i] = (i < int'(cfg.dims)) ? (coords[i][MAX_ORDER-1:0] & cmask) : '0;
    end
  end

  assign stg_data[0]    = point_in;
  assign stg_valid[0]   = in_point.valid;
  assign in_point.ready = stg_ready[0];

  for (genvar k = 1; k < MAX_ORDER; k++) begin : g_undo
    hpi_undo_stage #(
      .MAX_DIMS  (MAX_DIMS),
      .MAX_ORDER (MAX_ORDER),
      .LEVEL     (MAX_ORDER - k)
    ) u_undo (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg),
      .valid_i (stg_valid[k-1]),
      .ready_o (stg_ready[k-1]),
      .data_i  (stg_data[k-1]),
      .valid_o (stg_valid[k]),
      .ready_i (stg_ready[k]),
      .data_o  (stg_data[k])
    );
  end

  hpi_gray_stage #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_ORDER (MAX_ORDER)
  ) u_gray (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (stg_valid[MAX_ORDER-1]),
    .ready_o (stg_ready[MAX_ORDER-1]),
    .data_i  (stg_data[MAX_ORDER-1]),
    .valid_o (gray_valid),
    .ready_i (gray_ready),
    .data_o  (gray_data)
  );

  hpi_pack_stage #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_ORDER (MAX_ORDER)
  ) u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (gray_valid),
    .ready_o (gray_ready),
    .data_i  (gray_data),
    .valid_o (out_index.valid),
    .ready_i (pack_ready),
    .index_o (index)
  );

  assign pack_ready              = out_index.ready;
  assign out_index.hilbert_index = hpi_pkg::HPI_INDEX_W'(index);

  // Unused index bits above order times dimensions stay clear.
  a_index_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_index.valid |->
      ((out_index.hilbert_index >> (int'(cfg.order) * int'(cfg.dims))) == '0))
    else $error("hilbert index has bits above the curve width");

  // The input is only held off when the whole pipeline is backed up.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_point.ready |-> (out_index.valid && !out_index.ready && gray_valid))
    else $error("input stalled while the pipeline has room");

  // An output beat can only appear after something entered the Gray stage.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_index.valid) |-> $past(gray_valid))
    else $error("output beat without a preceding stage beat");

  // Reset leaves the default curve configuration.
  a_cfg_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |->
      (order_r == hpi_pkg::ORDER_RESET && dims_r == hpi_pkg::DIMS_RESET))
    else $error("configuration not at reset values");

endmodule
